@@ rtl/core/keypoint_radius_suppress_top_k_defines.svh @@
// ----------------------------------------------------------------------------
// keypoint_radius_suppress_top_k_defines
// assertion macros shared by the suppression block
// ----------------------------------------------------------------------------
`ifndef KEYPOINT_RADIUS_SUPPRESS_TOP_K_DEFINES_SVH
`define KEYPOINT_RADIUS_SUPPRESS_TOP_K_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define KPRS_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// trigger implies the result in the following cycle
`define KPRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define KPRS_ASSERT(lbl, clk, rst_n, cond, msg)
`define KPRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

@@ rtl/core/kprs_pkg.sv @@
// ----------------------------------------------------------------------------
// kprs_pkg
// field widths, entry layout and shared types of the suppression block
// ----------------------------------------------------------------------------
package kprs_pkg;

    // payload field widths
    localparam int COORD_W = 12;
    localparam int SCORE_W = 8;
    localparam int RANK_W  = 6;

    // stored entry layout: x, y, score from the low end
    localparam int ENTRY_W = 32;
    localparam int X_LSB   = 0;
    localparam int Y_LSB   = 12;
    localparam int S_LSB   = 24;

    // squared distance widths
    localparam int SQ_W    = 2 * COORD_W;
    localparam int R2_W    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int MAXF_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAXF   = 1'b1;

    localparam int RADIUS_RESET = 20;
    localparam logic [R2_W-1:0]   R2_RESET   = R2_W'(RADIUS_RESET * RADIUS_RESET);
    localparam logic [MAXF_W-1:0] MAXF_RESET = 6'd20;

    // selector controls from the sequencer
    typedef struct packed {
        logic start_frame;
        logic start_scan;
        logic sample;
        logic advance;
    } sel_ctrl_t;

endpackage

@@ rtl/core/kprs_store.sv @@
// ----------------------------------------------------------------------------
// kprs_store
// kept point memory, one write and one registered read port
// ----------------------------------------------------------------------------
module kprs_store #(
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [kprs_pkg::ENTRY_W-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [kprs_pkg::ENTRY_W-1:0] rdata
);
    import kprs_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/kprs_dist.sv @@
// ----------------------------------------------------------------------------
// kprs_dist
// squared distance of a stored point to the candidate, compared to radius
// ----------------------------------------------------------------------------
module kprs_dist (
    input  logic                         clk,
    input  logic [kprs_pkg::ENTRY_W-1:0] entry,
    input  logic [kprs_pkg::COORD_W-1:0] cand_x,
    input  logic [kprs_pkg::COORD_W-1:0] cand_y,
    input  logic [kprs_pkg::R2_W-1:0]    r2,
    output logic                         hit
);
    import kprs_pkg::*;

    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [SQ_W-1:0]    sq_x_reg;
    logic [SQ_W-1:0]    sq_y_reg;
    logic [SQ_W:0]      dist2;

    // absolute differences
    always_comb
    begin
        ex = entry[X_LSB +: COORD_W];
        ey = entry[Y_LSB +: COORD_W];
        dx = (cand_x > ex) ? (cand_x - ex) : (ex - cand_x);
        dy = (cand_y > ey) ? (cand_y - ey) : (ey - cand_y);
    end

    // squares, registered
    always_ff @(posedge clk)
    begin
        sq_x_reg <= dx * dx;
        sq_y_reg <= dy * dy;
    end

    // sum and radius compare
    assign dist2 = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign hit   = dist2 < (SQ_W + 1)'(r2);

endmodule

@@ rtl/core/kprs_select.sv @@
// ----------------------------------------------------------------------------
// kprs_select
// running best of one emission pass, ordered by score then store index
// ----------------------------------------------------------------------------
module kprs_select #(
    parameter int IDX_W = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kprs_pkg::sel_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]             idx,
    input  logic [kprs_pkg::ENTRY_W-1:0] entry,
    output logic [kprs_pkg::ENTRY_W-1:0] best_entry
);
    import kprs_pkg::*;

    logic               found_reg;
    logic               have_last_reg;
    logic [ENTRY_W-1:0] best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [SCORE_W-1:0] last_s_reg;
    logic [IDX_W-1:0]   last_idx_reg;

    logic [SCORE_W-1:0] s;
    logic [SCORE_W-1:0] best_s;
    logic               below_last;
    logic               take;

    // candidate must rank after the last emitted point and beat the best
    always_comb
    begin
        s          = entry[S_LSB +: SCORE_W];
        best_s     = best_reg[S_LSB +: SCORE_W];
        below_last = !have_last_reg || (s < last_s_reg) ||
                     ((s == last_s_reg) && (idx > last_idx_reg));
        take       = ctrl.sample && below_last && (!found_reg || (s > best_s));
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.start_scan)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (ctrl.start_frame)
            begin
                have_last_reg <= 1'b0;
            end
            else if (ctrl.advance)
            begin
                have_last_reg <= 1'b1;
            end
        end
    end

    // best and last emitted keys
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg     <= entry;
            best_idx_reg <= idx;
        end
        if (ctrl.advance)
        begin
            last_s_reg   <= best_s;
            last_idx_reg <= best_idx_reg;
        end
    end

    assign best_entry = best_reg;

endmodule

@@ rtl/core/keypoint_radius_suppress_top_k.sv @@
// ----------------------------------------------------------------------------
// keypoint_radius_suppress_top_k
// greedy radius suppression of corner keypoints with top-k emission by score
//
// keypoints enter on the pt channel (valid/stall), one transaction each, and
// the next keypoint is stalled until the last is done: one memory read per
// kept point through the distance pipeline, fewer when a nearby kept point
// ends the scan early. a kept point is appended to the store while it has room.
// the keypoint with frame_end starts emission: each result scans the store
// once, is loaded into the output register and leaves on the res channel in
// descending score order with ranks from 1.
// res is a register: the next keypoint is taken while the final result waits,
// and a stalled res holds its transaction and pauses emission.
// configuration writes are registered; write only while idle.
// reset clears the count, overflow flag and control registers; the store needs no
// clearing pass since only entries below the count are read.
// ----------------------------------------------------------------------------
`include "keypoint_radius_suppress_top_k_defines.svh"

module keypoint_radius_suppress_top_k #(
    parameter int STORE_DEPTH = 256,
    parameter int MAX_EMIT    = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [kprs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kprs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            pt_valid,
    output logic                            pt_stall,
    input  logic [kprs_pkg::COORD_W-1:0]    point_x,
    input  logic [kprs_pkg::COORD_W-1:0]    point_y,
    input  logic [kprs_pkg::SCORE_W-1:0]    score,
    input  logic                            frame_end,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [kprs_pkg::RANK_W-1:0]     rank,
    output logic [kprs_pkg::COORD_W-1:0]    out_x,
    output logic [kprs_pkg::COORD_W-1:0]    out_y,
    output logic [kprs_pkg::SCORE_W-1:0]    out_score,
    output logic                            overflowed,
    output logic                            last_result
);
    import kprs_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int LIM_W = $clog2(MAX_EMIT + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_COMMIT = 5'b00100,
        S_ESCAN  = 5'b01000,
        S_ELOAD  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               keep_reg, keep_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic [LIM_W-1:0]   limit_reg, limit_next;
    logic [LIM_W-1:0]   emit_reg, emit_next;
    logic [R2_W-1:0]    r2_reg, r2_next;
    logic [MAXF_W-1:0]  maxf_reg, maxf_next;
    logic               out_valid_reg, out_valid_next;

    logic [COORD_W-1:0] cand_x_reg;
    logic [COORD_W-1:0] cand_y_reg;
    logic [SCORE_W-1:0] cand_s_reg;
    logic               cand_fe_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [SCORE_W-1:0] out_s_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               pt_accept;
    logic               issue;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               dist_hit;
    logic               scan_hit;
    logic               drained;
    logic               store_ok;
    logic [CNT_W-1:0]   cnt_new;
    logic [LIM_W-1:0]   maxf_sat;
    logic [LIM_W-1:0]   lim_new;
    logic               out_free;
    logic               load_out;
    logic               last_emit;
    logic [ENTRY_W-1:0] best_entry;
    sel_ctrl_t          sel_ctrl;

    // datapath control terms
    always_comb
    begin
        pt_accept = pt_valid && (state_reg == S_IDLE);
        issue     = ((state_reg == S_SCAN) || (state_reg == S_ESCAN)) &&
                    (rd_cnt_reg < count_reg);
        scan_hit  = v2_reg && dist_hit;
        drained   = !issue && !v1_reg && !v2_reg;
        store_ok  = keep_reg && (count_reg < CNT_W'(STORE_DEPTH));
        cnt_new   = store_ok ? (count_reg + CNT_W'(1)) : count_reg;
        mem_we    = (state_reg == S_COMMIT) && store_ok;
        mem_wdata = {cand_s_reg, cand_y_reg, cand_x_reg};
        maxf_sat  = (int'(maxf_reg) > MAX_EMIT) ? LIM_W'(MAX_EMIT) : LIM_W'(maxf_reg);
        lim_new   = (int'(cnt_new) < int'(maxf_sat)) ? LIM_W'(cnt_new) : maxf_sat;
        out_free  = !out_valid_reg || !res_stall;
        load_out  = (state_reg == S_ELOAD) && out_free;
        last_emit = (emit_reg == limit_reg);
    end

    // selector controls
    always_comb
    begin
        sel_ctrl.start_frame = (state_reg == S_COMMIT) && cand_fe_reg;
        sel_ctrl.start_scan  = ((state_reg == S_COMMIT) && cand_fe_reg) ||
                               (load_out && !last_emit);
        sel_ctrl.sample      = (state_reg == S_ESCAN) && v1_reg;
        sel_ctrl.advance     = load_out && !last_emit;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        keep_next   = keep_reg;
        rd_cnt_next = issue ? (rd_cnt_reg + CNT_W'(1)) : rd_cnt_reg;
        v1_next     = issue;
        v2_next     = (state_reg == S_SCAN) && v1_reg;
        limit_next  = limit_reg;
        emit_next   = emit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pt_valid)
                begin
                    rd_cnt_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    keep_next  = 1'b0;
                    v1_next    = 1'b0;
                    v2_next    = 1'b0;
                    state_next = S_COMMIT;
                end
                else if (drained)
                begin
                    keep_next  = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                count_next = cnt_new;
                if (keep_reg && !store_ok)
                begin
                    ovf_next = 1'b1;
                end
                if (!cand_fe_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (lim_new == '0)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    limit_next  = lim_new;
                    emit_next   = LIM_W'(1);
                    rd_cnt_next = '0;
                    state_next  = S_ESCAN;
                end
            end
            S_ESCAN:
            begin
                if (drained)
                begin
                    state_next = S_ELOAD;
                end
            end
            S_ELOAD:
            begin
                if (out_free)
                begin
                    if (last_emit)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next   = emit_reg + LIM_W'(1);
                        rd_cnt_next = '0;
                        state_next  = S_ESCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        r2_next   = r2_reg;
        maxf_next = maxf_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIUS: r2_next   = R2_W'(cfg_data) * R2_W'(cfg_data);
                REG_MAXF:   maxf_next = cfg_data[MAXF_W-1:0];
            endcase
        end
    end

    // output register valid
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && res_stall;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            keep_reg      <= 1'b0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            limit_reg     <= '0;
            emit_reg      <= '0;
            r2_reg        <= R2_RESET;
            maxf_reg      <= MAXF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            keep_reg      <= keep_next;
            rd_cnt_reg    <= rd_cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            limit_reg     <= limit_next;
            emit_reg      <= emit_next;
            r2_reg        <= r2_next;
            maxf_reg      <= maxf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pt_accept)
        begin
            cand_x_reg  <= point_x;
            cand_y_reg  <= point_y;
            cand_s_reg  <= score;
            cand_fe_reg <= frame_end;
        end
        if (issue)
        begin
            idx1_reg <= rd_cnt_reg[IDX_W-1:0];
        end
        if (load_out)
        begin
            rank_reg     <= RANK_W'(emit_reg);
            out_x_reg    <= best_entry[X_LSB +: COORD_W];
            out_y_reg    <= best_entry[Y_LSB +: COORD_W];
            out_s_reg    <= best_entry[S_LSB +: SCORE_W];
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= last_emit;
        end
    end

    // kept point store
    kprs_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // distance pipeline
    kprs_dist u_dist (
        .clk    (clk),
        .entry  (mem_rdata),
        .cand_x (cand_x_reg),
        .cand_y (cand_y_reg),
        .r2     (r2_reg),
        .hit    (dist_hit)
    );

    // best score selector
    kprs_select #(
        .IDX_W (IDX_W)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sel_ctrl),
        .idx        (idx1_reg),
        .entry      (mem_rdata),
        .best_entry (best_entry)
    );

    // ports
    assign pt_stall    = (state_reg != S_IDLE);
    assign res_valid   = out_valid_reg;
    assign rank        = rank_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_score   = out_s_reg;
    assign overflowed  = out_ovf_reg;
    assign last_result = out_last_reg;

    // assertions
    `KPRS_ASSERT(a_count_bound, clk, rst_n,
        count_reg <= CNT_W'(STORE_DEPTH), "kept count above depth")
    `KPRS_ASSERT(a_hit_in_scan, clk, rst_n,
        !v2_reg || (state_reg == S_SCAN), "distance tag outside scan")
    `KPRS_ASSERT(a_emit_range, clk, rst_n,
        !((state_reg == S_ESCAN) || (state_reg == S_ELOAD)) ||
        ((count_reg != '0) && (emit_reg != '0) && (emit_reg <= limit_reg)),
        "emission rank out of range")
    `KPRS_ASSERT_NEXT(a_frame_clear, clk, rst_n, load_out && last_emit,
        (state_reg == S_IDLE) && (count_reg == '0) && !ovf_reg,
        "frame state not cleared")

endmodule
